@@ rtl/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared codes and constants for the text console writer: command codes,
// control bytes, tab stop and attribute reset value.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // command codes of an input item
  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // control bytes handled by the put command
  localparam logic [7:0] BYTE_BACKSPACE = 8'h08;
  localparam logic [7:0] BYTE_TAB       = 8'h09;
  localparam logic [7:0] BYTE_LF        = 8'h0A;
  localparam logic [7:0] BYTE_CR        = 8'h0D;

  // tab stops every eight columns
  localparam int unsigned TAB_STOP = 8;

  // attribute register reset value and register index
  localparam logic [7:0] ATTR_RESET = 8'h0F;
  localparam logic [1:0] REG_ATTR   = 2'd0;

endpackage : tcw_pkg

@@ rtl/text_console_writer_unit.sv @@
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Character-cell text console: a screen store of character and attribute bytes
// with one write and one read port, a cursor, and a small sequencer for scroll and clear.
// ----------------------------------------------------------------------------
// Sequence: put, tab, return, line feed, read and unused commands go from accept
//   to the finishing state, then result; backspace adds a write state (read-modify-write of the cell).
// A scroll copies the rows below the top one up a row, then clears the bottom two
//   rows; a clear zeroes every cell of the store, one store write per cycle.
// Throughput: one item at a time; in_stall_o stays high until the result is loaded.
// Reset: a clearing pass over every cell zeroes the store; no item taken
module text_console_writer_unit #(
  parameter int unsigned SCREEN_COLUMNS = 80,
  parameter int unsigned SCREEN_ROWS    = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  char_code_i,
  input  logic [10:0] cell_index_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [10:0] cursor_position_o,
  output logic [7:0]  read_char_o,
  output logic [7:0]  read_attribute_o,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tcw_pkg::*;

  localparam int unsigned CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int unsigned COPY_COUNT = (SCREEN_ROWS - 2) * SCREEN_COLUMNS;
  localparam int unsigned ADDR_W     = $clog2(CELL_COUNT);
  localparam int unsigned COL_W      = $clog2(SCREEN_COLUMNS);
  localparam int unsigned COLN_W     = $clog2(SCREEN_COLUMNS + TAB_STOP);
  localparam int unsigned ROW_W      = $clog2(SCREEN_ROWS);
  localparam int unsigned WIDE_W     = (ADDR_W > 11) ? ADDR_W : 11;

  localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(SCREEN_COLUMNS);
  localparam logic [ADDR_W-1:0] CLEAR_LAST = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] COPY_LAST  = ADDR_W'(COPY_COUNT - 1);
  localparam logic [COLN_W-1:0] COLS_N     = COLN_W'(SCREEN_COLUMNS);
  localparam logic [COLN_W-1:0] TAB_N      = COLN_W'(TAB_STOP);
  localparam logic [COLN_W-1:0] TAB_MASK   = ~COLN_W'(TAB_STOP - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(SCREEN_ROWS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BS_WR,
    ST_SCROLL,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e            state_q, state_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [7:0]        attr_q, attr_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic [ADDR_W-1:0] wr_addr_q, wr_addr_d;
  logic              cp_we_q, cp_we_d;
  logic              boot_q, boot_d;
  logic              rd_ok_q, rd_ok_d;
  logic              out_valid_q, out_valid_d;
  logic [10:0]       pos_q, pos_d;
  logic [7:0]        rchar_q, rchar_d;
  logic [7:0]        rattr_q, rattr_d;

  // screen store ports
  logic [15:0]       mem [CELL_COUNT];
  logic [15:0]       rd_data_q;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_wa, mem_ra;
  logic [15:0]       mem_wd;

  logic              accept;
  logic              cfg_wr;
  logic [ADDR_W-1:0] cur_addr;
  logic [WIDE_W-1:0] pos_ext;
  logic [WIDE_W-1:0] idx_ext;
  logic              idx_ok;
  logic [COLN_W-1:0] col_w, col_n;
  logic              row_inc;
  logic [ROW_W-1:0]  row_n;
  logic              is_bs, is_print;

  // handshake and register port
  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cursor_position_o = pos_q;
  assign read_char_o       = rchar_q;
  assign read_attribute_o  = rattr_q;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_ATTR);
  assign prdata = (paddr == REG_ATTR) ? {24'd0, attr_q} : 32'd0;

  // linear cursor address and cell index decode
  assign cur_addr = ADDR_W'(row_q) * COLS_A + ADDR_W'(col_q);
  assign pos_ext  = WIDE_W'(cur_addr);
  assign idx_ext  = WIDE_W'(cell_index_i);
  assign idx_ok   = ({21'd0, cell_index_i} < 32'(CELL_COUNT));

  // cursor motion for the put command
  always_comb begin
    col_w    = COLN_W'(col_q);
    col_n    = col_w;
    row_inc  = 1'b0;
    is_bs    = (char_code_i == BYTE_BACKSPACE);
    is_print = 1'b0;
    case (char_code_i)
      BYTE_BACKSPACE: col_n = col_w;
      BYTE_TAB:       col_n = (col_w + TAB_N) & TAB_MASK;
      BYTE_CR:        col_n = '0;
      BYTE_LF: begin
        col_n   = '0;
        row_inc = 1'b1;
      end
      default: begin
        col_n    = col_w + COLN_W'(1);
        is_print = 1'b1;
      end
    endcase
    if (col_n >= COLS_N) begin
      col_n   = '0;
      row_inc = 1'b1;
    end
    row_n = row_q + ROW_W'(row_inc);
  end

  // store port selection
  always_comb begin
    mem_we = 1'b0;
    mem_wa = ptr_q;
    mem_wd = 16'd0;
    mem_re = 1'b0;
    mem_ra = ptr_q + COLS_A;
    case (state_q)
      ST_IDLE: begin
        if (accept && command_i == CMD_PUT && is_print) begin
          mem_we = 1'b1;
          mem_wa = cur_addr;
          mem_wd = {attr_q, char_code_i};
        end
        if (accept && command_i == CMD_PUT && is_bs && col_q != '0) begin
          mem_re = 1'b1;
          mem_ra = cur_addr - ADDR_W'(1);
        end
        if (accept && command_i == CMD_READ && idx_ok) begin
          mem_re = 1'b1;
          mem_ra = idx_ext[ADDR_W-1:0];
        end
      end
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_BS_WR: begin
        mem_we = 1'b1;
        mem_wa = wr_addr_q;
        mem_wd = {rd_data_q[15:8], 8'd0};
      end
      ST_SCROLL, ST_DRAIN: begin
        mem_we = cp_we_q;
        mem_wa = wr_addr_q;
        mem_wd = rd_data_q;
        mem_re = (state_q == ST_SCROLL);
      end
      default: ;
    endcase
  end

  // screen store, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_ra];
    end
  end

  // sequencer next state
  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    attr_d      = cfg_wr ? pwdata[7:0] : attr_q;
    ptr_d       = ptr_q;
    wr_addr_d   = wr_addr_q;
    cp_we_d     = 1'b0;
    boot_d      = boot_q;
    rd_ok_d     = rd_ok_q;
    out_valid_d = out_valid_q && out_stall_i;
    pos_d       = pos_q;
    rchar_d     = rchar_q;
    rattr_d     = rattr_q;
    case (state_q)
      ST_CLEAR: begin
        ptr_d = ptr_q + ADDR_W'(1);
        if (ptr_q == CLEAR_LAST) begin
          state_d = boot_q ? ST_IDLE : ST_FINISH;
          boot_d  = 1'b0;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          rd_ok_d = 1'b0;
          state_d = ST_FINISH;
          case (command_i)
            CMD_PUT: begin
              if (is_bs) begin
                if (col_q != '0) begin
                  col_d     = col_q - COL_W'(1);
                  wr_addr_d = cur_addr - ADDR_W'(1);
                  state_d   = ST_BS_WR;
                end
              end else begin
                col_d = COL_W'(col_n);
                row_d = row_n;
                if (row_n == ROW_LAST) begin
                  row_d   = row_n - ROW_W'(1);
                  ptr_d   = '0;
                  state_d = ST_SCROLL;
                end
              end
            end
            CMD_CLEAR: begin
              col_d   = '0;
              row_d   = '0;
              ptr_d   = '0;
              state_d = ST_CLEAR;
            end
            CMD_READ: rd_ok_d = idx_ok;
            default: ;
          endcase
        end
      end
      ST_BS_WR: state_d = ST_FINISH;
      ST_SCROLL: begin
        ptr_d     = ptr_q + ADDR_W'(1);
        cp_we_d   = 1'b1;
        wr_addr_d = ptr_q;
        if (ptr_q == COPY_LAST) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_CLEAR;
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          pos_d       = pos_ext[10:0];
          rchar_d     = rd_ok_q ? rd_data_q[7:0] : 8'd0;
          rattr_d     = rd_ok_q ? rd_data_q[15:8] : 8'd0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      col_q       <= '0;
      row_q       <= '0;
      attr_q      <= ATTR_RESET;
      ptr_q       <= '0;
      wr_addr_q   <= '0;
      cp_we_q     <= 1'b0;
      boot_q      <= 1'b1;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      rchar_q     <= '0;
      rattr_q     <= '0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      attr_q      <= attr_d;
      ptr_q       <= ptr_d;
      wr_addr_q   <= wr_addr_d;
      cp_we_q     <= cp_we_d;
      boot_q      <= boot_d;
      rd_ok_q     <= rd_ok_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
      rchar_q     <= rchar_d;
      rattr_q     <= rattr_d;
    end
  end

`ifndef SYNTHESIS
  // cursor stays inside the screen and above the last row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(col_q) < SCREEN_COLUMNS) && (int'(row_q) < SCREEN_ROWS - 1))
    else $error("cursor left the screen");

  // every store access stays inside the screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!mem_we || (int'(mem_wa) < CELL_COUNT)) && (!mem_re || (int'(mem_ra) < CELL_COUNT)))
    else $error("store access out of range");

  // an accepted item holds off the next one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second item taken while one is in flight");

  // a result appears only after the finishing step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("result raised outside the finishing step");
`endif

endmodule : text_console_writer_unit

@@ sim/text_console_writer_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_unit_tb
// Self-checking bench for the text console writer. A mirror of the screen
// store, cursor and attribute register predicts every result item; results
// are compared field by field in arrival order. Directed items hit the
// control bytes and field extremes, random text lines drive wrap and scroll,
// a long receiver hold follows, then mixed random traffic under several attributes.
// ----------------------------------------------------------------------------
module text_console_writer_unit_tb;
  import tcw_pkg::*;

  localparam int unsigned COLS  = 80;
  localparam int unsigned ROWS  = 25;
  localparam int unsigned CELLS = COLS * ROWS;

  // command 3 is decoded but does nothing
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] ATTR_ADDR  = 2'(4 * REG_ATTR);

  // a scroll or clear walks the whole store
  localparam int unsigned WATCHDOG_LIMIT   = 20000;
  localparam int unsigned SETTLE_CYCLES    = 40;
  localparam int unsigned LONG_HOLD_CYCLES = 400;

  typedef struct packed {
    logic [10:0] cursor_position;
    logic [7:0]  read_char;
    logic [7:0]  read_attribute;
  } console_reply_t;

  typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_e;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  command_i;
  logic [7:0]  char_code_i;
  logic [10:0] cell_index_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [10:0] cursor_position_o;
  logic [7:0]  read_char_o;
  logic [7:0]  read_attribute_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // mirror of the console state
  logic [15:0] mirror_cells [CELLS];
  int unsigned mirror_col;
  int unsigned mirror_row;
  logic [7:0]  mirror_attr;

  console_reply_t reply_fifo [$];
  int unsigned    reply_errors = 0;
  int unsigned    items_sent   = 0;
  int unsigned    idle_cycles  = 0;
  int unsigned    burst_left   = 0;
  int unsigned    long_hold_seq = 0;
  bit             sender_gaps  = 1'b1;
  stall_mode_e    stall_mode   = STALL_NONE;

  text_console_writer_unit #(
    .SCREEN_COLUMNS(COLS),
    .SCREEN_ROWS   (ROWS)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .char_code_i      (char_code_i),
    .cell_index_i     (cell_index_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .cursor_position_o(cursor_position_o),
    .read_char_o      (read_char_o),
    .read_attribute_o (read_attribute_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // one console step on the mirror, returns the result item it causes
  function automatic console_reply_t console_step(input logic [1:0] cmd,
                                                  input logic [7:0] ch,
                                                  input logic [10:0] idx);
    console_reply_t rep;
    int unsigned    addr;
    rep = '0;
    if (cmd == CMD_PUT) begin
      if (mirror_row >= ROWS || mirror_col >= COLS) begin
        mirror_row = 0;
        mirror_col = 0;
      end
      case (ch)
        BYTE_BACKSPACE: begin
          // only the character byte is blanked, attribute stays
          if (mirror_col > 0) begin
            mirror_col--;
            addr = mirror_row * COLS + mirror_col;
            mirror_cells[addr][7:0] = 8'h00;
          end
        end
        BYTE_TAB: mirror_col = (mirror_col + TAB_STOP) & ~(TAB_STOP - 1);
        BYTE_CR:  mirror_col = 0;
        BYTE_LF: begin
          mirror_col = 0;
          mirror_row++;
        end
        default: begin
          addr = mirror_row * COLS + mirror_col;
          mirror_cells[addr] = {mirror_attr, ch};
          mirror_col++;
        end
      endcase
      if (mirror_col >= COLS) begin
        mirror_col = 0;
        mirror_row++;
      end
      // scroll once the cursor lands on the last row
      if (mirror_row >= ROWS - 1) begin
        for (addr = 0; addr < (ROWS - 2) * COLS; addr++)
          mirror_cells[addr] = mirror_cells[addr + COLS];
        for (addr = (ROWS - 2) * COLS; addr < CELLS; addr++)
          mirror_cells[addr] = '0;
        mirror_row--;
      end
    end else if (cmd == CMD_CLEAR) begin
      for (addr = 0; addr < CELLS; addr++) mirror_cells[addr] = '0;
      mirror_col = 0;
      mirror_row = 0;
    end else if (cmd == CMD_READ && idx < CELLS) begin
      rep.read_char      = mirror_cells[idx][7:0];
      rep.read_attribute = mirror_cells[idx][15:8];
    end
    rep.cursor_position = 11'(mirror_row * COLS + mirror_col);
    return rep;
  endfunction

  // any byte that prints
  function automatic logic [7:0] pick_glyph();
    logic [7:0] ch;
    ch = 8'($urandom);
    while (ch == BYTE_BACKSPACE || ch == BYTE_TAB || ch == BYTE_LF || ch == BYTE_CR)
      ch = 8'($urandom);
    return ch;
  endfunction

  // mostly cells near the cursor, sometimes anywhere, sometimes out of range
  function automatic logic [10:0] pick_read_index();
    int unsigned sel;
    int unsigned row;
    sel = $urandom_range(0, 9);
    row = (sel[0] && mirror_row > 0) ? mirror_row - 1 : mirror_row;
    if (sel < 5) return 11'(row * COLS + $urandom_range(0, COLS - 1));
    if (sel < 9) return 11'($urandom_range(0, CELLS - 1));
    return 11'($urandom_range(0, 2047));
  endfunction

  // compare result items, then predict for the item accepted at this edge
  always @(posedge clk_i) begin : reply_check
    console_reply_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (reply_fifo.size() == 0) begin
          $error("unexpected result item: cursor_position %0d", cursor_position_o);
          reply_errors++;
        end else begin
          want = reply_fifo.pop_front();
          if (cursor_position_o !== want.cursor_position) begin
            $error("cursor_position: expected %0d, got %0d",
                   want.cursor_position, cursor_position_o);
            reply_errors++;
          end
          if (read_char_o !== want.read_char) begin
            $error("read_char: expected 0x%02h, got 0x%02h", want.read_char, read_char_o);
            reply_errors++;
          end
          if (read_attribute_o !== want.read_attribute) begin
            $error("read_attribute: expected 0x%02h, got 0x%02h",
                   want.read_attribute, read_attribute_o);
            reply_errors++;
          end
        end
      end
      if (in_valid_i && !in_stall_o)
        reply_fifo.push_back(console_step(command_i, char_code_i, cell_index_i));
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver stall pattern, with a long hold on request
  initial begin : receiver_stall
    int unsigned hold_left;
    int unsigned tick;
    int unsigned seen_seq;
    hold_left   = 0;
    tick        = 0;
    seen_seq    = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      tick++;
      if (long_hold_seq != seen_seq) begin
        seen_seq  = long_hold_seq;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i = 1'b1;
      end else begin
        case (stall_mode)
          STALL_RANDOM:   out_stall_i = ($urandom_range(0, 99) < 35);
          STALL_PERIODIC: out_stall_i = ((tick % 7) >= 4);
          default:        out_stall_i = 1'b0;
        endcase
      end
    end
  end

  // offer one item and hold it until accepted; bursts with random gaps
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] ch,
                           input logic [10:0] idx);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (sender_gaps && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    command_i    = cmd;
    char_code_i  = ch;
    cell_index_i = idx;
    in_valid_i   = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  // stop offering and wait for every outstanding result item
  task automatic wait_results_done();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (reply_fifo.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // register write while idle, then read it back
  task automatic write_attribute(input logic [7:0] value);
    wait_results_done();
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ATTR_ADDR;
    pwdata  = {24'($urandom), value};
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    mirror_attr = value;
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[7:0] !== value) begin
      $error("text_attribute: expected 0x%02h, got 0x%02h", value, prdata[7:0]);
      reply_errors++;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // store must read as zero after the clearing pass
  task automatic test_reset_state();
    send_item(CMD_READ, 8'h00, 11'd0);
    send_item(CMD_READ, 8'hFF, 11'(CELLS - 1));
    send_item(CMD_READ, 8'h00, 11'h7FF);
  endtask

  // printing with the reset attribute and every control byte
  task automatic test_control_bytes();
    send_item(CMD_PUT, 8'h00, 11'h7FF);
    send_item(CMD_PUT, 8'hFF, 11'h000);
    send_item(CMD_PUT, 8'h41, 11'h555);
    send_item(CMD_READ, 8'hFF, 11'd0);
    send_item(CMD_READ, 8'h00, 11'd2);
    // backspace keeps the attribute byte
    send_item(CMD_PUT, BYTE_BACKSPACE, 11'h2AA);
    send_item(CMD_READ, 8'h00, 11'd2);
    send_item(CMD_PUT, BYTE_BACKSPACE, 11'd0);
    send_item(CMD_PUT, BYTE_BACKSPACE, 11'd0);
    // backspace at column zero does nothing
    send_item(CMD_PUT, BYTE_BACKSPACE, 11'd0);
    send_item(CMD_READ, 8'h00, 11'd0);
    send_item(CMD_PUT, BYTE_TAB, 11'd0);
    send_item(CMD_PUT, BYTE_CR, 11'd0);
    send_item(CMD_PUT, BYTE_LF, 11'd0);
    send_item(CMD_UNUSED, 8'hFF, 11'h7FF);
    send_item(CMD_CLEAR, 8'hAA, 11'h2AA);
    send_item(CMD_READ, 8'h00, 11'd1);
  endtask

  // extreme attribute values land in printed cells
  task automatic test_attribute_extremes();
    write_attribute(8'hFF);
    send_item(CMD_PUT, pick_glyph(), 11'd0);
    send_item(CMD_READ, 8'h00, 11'd0);
    write_attribute(8'h00);
    send_item(CMD_PUT, pick_glyph(), 11'd0);
    send_item(CMD_READ, 8'h00, 11'd1);
  endtask

  // lines of random text: column wrap, tabs and many scrolls
  task automatic test_line_traffic();
    int unsigned start;
    int unsigned len;
    int unsigned k;
    write_attribute(8'($urandom));
    stall_mode  = STALL_RANDOM;
    sender_gaps = 1'b1;
    start = items_sent;
    while (items_sent - start < 600) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 100) : $urandom_range(0, 20);
      for (k = 0; k < len; k++) begin
        case ($urandom_range(0, 15))
          0:       send_item(CMD_PUT, BYTE_TAB, 11'($urandom));
          1:       send_item(CMD_PUT, BYTE_BACKSPACE, 11'($urandom));
          default: send_item(CMD_PUT, pick_glyph(), 11'($urandom));
        endcase
      end
      // read back, then usually end the line
      send_item(CMD_READ, 8'($urandom), pick_read_index());
      send_item(CMD_READ, 8'($urandom), pick_read_index());
      case ($urandom_range(0, 9))
        0: ;
        1, 2: begin
          send_item(CMD_PUT, BYTE_CR, 11'($urandom));
          send_item(CMD_PUT, BYTE_LF, 11'($urandom));
        end
        default: send_item(CMD_PUT, BYTE_LF, 11'($urandom));
      endcase
    end
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    int unsigned k;
    wait_results_done();
    stall_mode  = STALL_NONE;
    sender_gaps = 1'b0;
    @(negedge clk_i);
    long_hold_seq++;
    for (k = 0; k < 40; k++) begin
      if (k % 5 == 4) send_item(CMD_READ, 8'($urandom), pick_read_index());
      else send_item(CMD_PUT, pick_glyph(), 11'($urandom));
    end
    wait_results_done();
  endtask

  // mixed random traffic in phases of attribute, stall and gap settings
  task automatic test_random_mix();
    int unsigned ph;
    int unsigned n;
    int unsigned sel;
    for (ph = 0; ph < 4; ph++) begin
      write_attribute((ph == 0) ? 8'h00 : (ph == 1) ? 8'hFF : 8'($urandom));
      stall_mode  = (ph == 0) ? STALL_NONE : (ph == 2) ? STALL_PERIODIC : STALL_RANDOM;
      sender_gaps = (ph != 2);
      for (n = 0; n < 300; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 50)      send_item(CMD_PUT, 8'($urandom), 11'($urandom));
        else if (sel < 58) send_item(CMD_PUT, BYTE_BACKSPACE, 11'($urandom));
        else if (sel < 64) send_item(CMD_PUT, BYTE_TAB, 11'($urandom));
        else if (sel < 67) send_item(CMD_PUT, BYTE_CR, 11'($urandom));
        else if (sel < 70) send_item(CMD_PUT, BYTE_LF, 11'($urandom));
        else if (sel < 90) send_item(CMD_READ, 8'($urandom), pick_read_index());
        else if (sel < 93) send_item(CMD_CLEAR, 8'($urandom), 11'($urandom));
        else               send_item(CMD_UNUSED, 8'($urandom), 11'($urandom));
      end
    end
  endtask

  // main sequence
  initial begin
    int unsigned k;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    command_i    = CMD_PUT;
    char_code_i  = 8'h00;
    cell_index_i = 11'd0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = ATTR_ADDR;
    pwdata       = 32'd0;
    for (k = 0; k < CELLS; k++) mirror_cells[k] = '0;
    mirror_col  = 0;
    mirror_row  = 0;
    mirror_attr = ATTR_RESET;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_control_bytes();
    test_attribute_extremes();
    test_line_traffic();
    test_backpressure();
    test_random_mix();

    wait_results_done();
    if (reply_errors == 0 && reply_fifo.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
